[rtl/btli_pkg.sv]
// Shared types and constants for the breakpoint table interpolator.
// No dependencies.
`default_nettype none
package btli_pkg;
    localparam int MAX_POINTS_DEF    = 16;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int CNT_W             = 5;

    localparam logic [1:0] REG_TIME_COUNT     = 2'd0;
    localparam logic [1:0] REG_STRENGTH_COUNT = 2'd1;
    localparam logic [1:0] REG_WIDTH_COUNT    = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DIVIDE,
        ST_MULT,
        ST_SUM,
        ST_OUT
    } ctrl_state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // write table entry from input
        logic start;      // capture query, reset search
        logic search;     // examine one breakpoint
        logic div_start;  // set up divider
        logic div_step;   // one quotient bit
        logic mult;       // register the products
        logic sum;        // form and saturate results
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic search_done;
        logic need_div;
        logic div_done;
    } dp_stat_t;
endpackage
`default_nettype wire

[rtl/btli_ctrl.sv]
// Sequencer for the interpolator: load, search, divide, multiply, output.
// Depends on btli_pkg.
`default_nettype none
module btli_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_fire,
    input  wire logic                in_mode,
    input  wire logic                out_fire,
    input  wire btli_pkg::dp_stat_t  stat,
    output btli_pkg::dp_cmd_t        cmd,
    output logic                     s_ready,
    output logic                     m_valid
);
    import btli_pkg::*;

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (in_fire && in_mode) state_next = ST_SEARCH;
            ST_SEARCH:
            begin
                if (stat.search_done)
                    state_next = stat.need_div ? ST_DIVIDE : ST_SUM;
            end
            ST_DIVIDE: if (stat.div_done) state_next = ST_MULT;
            ST_MULT:   state_next = ST_SUM;
            ST_SUM:    state_next = ST_OUT;
            ST_OUT:    if (out_fire) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd = '0;
        s_ready = 1'b0;
        m_valid = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_ready   = 1'b1;
                cmd.load  = in_fire && !in_mode;
                cmd.start = in_fire && in_mode;
            end
            ST_SEARCH:
            begin
                cmd.search    = !stat.search_done;
                cmd.div_start = stat.search_done && stat.need_div;
            end
            ST_DIVIDE: cmd.div_step = !stat.div_done;
            ST_MULT:   cmd.mult = 1'b1;
            ST_SUM:    cmd.sum = 1'b1;
            ST_OUT:    m_valid = 1'b1;
            default:   cmd = '0;
        endcase
    end

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_ready |-> !m_valid) else $error("ready while result pending");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid && !out_fire) |=> m_valid) else $error("result dropped");
    a_start_search: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> state_reg == ST_SEARCH) else $error("query not started");
endmodule
`default_nettype wire

[rtl/btli_datapath.sv]
// Tables, serial search, restoring divider, multipliers and saturation.
// Depends on btli_pkg.
`default_nettype none
module btli_datapath #(
    parameter int FRACTION_BITS = btli_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire btli_pkg::dp_cmd_t      cmd,
    output btli_pkg::dp_stat_t          stat,
    input  wire logic [3:0]             entry_index,
    input  wire logic signed [31:0]     entry_time,
    input  wire logic signed [31:0]     entry_strength,
    input  wire logic signed [31:0]     entry_width,
    input  wire logic signed [31:0]     query_time,
    input  wire logic [btli_pkg::CNT_W-1:0] time_count,
    input  wire logic [btli_pkg::CNT_W-1:0] strength_count,
    input  wire logic [btli_pkg::CNT_W-1:0] width_count,
    output logic signed [31:0]          strength_out,
    output logic signed [31:0]          width_out,
    output logic [btli_pkg::CNT_W-1:0]  segment,
    output logic                        clamped
);
    import btli_pkg::*;

    // table depth is tied to the 4-bit entry index and 5-bit segment fields
    localparam int MAX_POINTS = MAX_POINTS_DEF;
    localparam int IW   = $clog2(MAX_POINTS);
    localparam int SW   = $clog2(MAX_POINTS + 1);
    localparam int NW   = 33 + FRACTION_BITS;   // numerator bits
    localparam int RW   = FRACTION_BITS + 1;    // ratio bits, r <= 2^F
    localparam int QCW  = $clog2(NW + 1);
    localparam int PW   = 32 + RW + 1;

    logic signed [31:0] t_mem [MAX_POINTS];
    logic signed [31:0] s_mem [MAX_POINTS];
    logic signed [31:0] w_mem [MAX_POINTS];

    // effective counts: zero acts as one, above depth acts as depth
    function automatic logic [SW-1:0] eff(input logic [CNT_W-1:0] c);
        logic [SW-1:0] r;
        if (c == '0) r = SW'(1);
        else if (32'(c) > MAX_POINTS) r = SW'(MAX_POINTS);
        else r = SW'(c);
        return r;
    endfunction

    logic [SW-1:0] tc, sc, wc;
    assign tc = eff(time_count);
    assign sc = eff(strength_count);
    assign wc = eff(width_count);

    // table writes
    always_ff @(posedge clk)
    begin
        if (cmd.load && 32'(entry_index) < MAX_POINTS)
        begin
            t_mem[entry_index[IW-1:0]] <= entry_time;
            s_mem[entry_index[IW-1:0]] <= entry_strength;
            w_mem[entry_index[IW-1:0]] <= entry_width;
        end
    end

    // serial first-match search
    logic signed [31:0] q_reg;
    logic [SW-1:0] idx_reg;
    logic          found_reg, done_reg;
    logic [SW-1:0] seg;
    logic          cs_flag, cw_flag, need;
    logic signed [31:0] t_cur;

    assign t_cur = t_mem[idx_reg[IW-1:0]];
    assign seg = found_reg ? idx_reg : SW'(MAX_POINTS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            found_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else if (cmd.start)
        begin
            idx_reg   <= '0;
            found_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else if (cmd.search)
        begin
            if (idx_reg >= tc)
                done_reg <= 1'b1;
            else if (t_cur >= q_reg)
            begin
                found_reg <= 1'b1;
                done_reg  <= 1'b1;
            end
            else
                idx_reg <= idx_reg + SW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
            q_reg <= query_time;
    end

    assign cs_flag = !found_reg || seg >= sc || seg == '0;
    assign cw_flag = !found_reg || seg >= wc || seg == '0;
    assign need    = !cs_flag || !cw_flag;
    assign stat.search_done = done_reg;
    assign stat.need_div    = need;

    // restoring divider, one quotient bit per cycle
    logic [NW-1:0]  num_reg;
    logic [32:0]    den_reg;
    logic [33:0]    rem_reg;
    logic [QCW-1:0] cnt_reg;
    logic [33:0]    rem_sh;
    logic [IW-1:0]  lo_idx;
    logic signed [32:0] diff_n, diff_d;

    assign lo_idx = IW'(seg - SW'(1));
    assign diff_n = 33'(q_reg) - 33'(t_mem[lo_idx]);
    assign diff_d = 33'(t_mem[seg[IW-1:0]]) - 33'(t_mem[lo_idx]);
    assign rem_sh = {rem_reg[32:0], num_reg[NW-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (cmd.div_start)
            cnt_reg <= QCW'(NW);
        else if (cmd.div_step)
            cnt_reg <= cnt_reg - QCW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            num_reg <= {diff_n[32:0], FRACTION_BITS'(0)};
            den_reg <= diff_d;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (rem_sh >= {1'b0, den_reg})
            begin
                rem_reg <= rem_sh - {1'b0, den_reg};
                num_reg <= {num_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                num_reg <= {num_reg[NW-2:0], 1'b0};
            end
        end
    end
    assign stat.div_done = cnt_reg == '0;

    // products r*y[L] and (2^F - r)*y[L-1]
    logic [RW-1:0] r_val, rc_val;
    logic signed [PW-1:0] ps1_reg, ps0_reg, pw1_reg, pw0_reg;
    assign r_val  = num_reg[RW-1:0];
    assign rc_val = RW'(1 << FRACTION_BITS) - r_val;

    always_ff @(posedge clk)
    begin
        if (cmd.mult)
        begin
            ps1_reg <= PW'(s_mem[seg[IW-1:0]] * $signed({1'b0, r_val}));
            ps0_reg <= PW'(s_mem[lo_idx] * $signed({1'b0, rc_val}));
            pw1_reg <= PW'(w_mem[seg[IW-1:0]] * $signed({1'b0, r_val}));
            pw0_reg <= PW'(w_mem[lo_idx] * $signed({1'b0, rc_val}));
        end
    end

    function automatic logic signed [31:0] sat_shift(input logic signed [PW:0] v);
        logic signed [PW:0] s;
        s = v >>> FRACTION_BITS;
        if (s > (PW+1)'(32'sh7fffffff)) return 32'sh7fffffff;
        else if (s < -(PW+1)'(33'sh80000000)) return 32'sh80000000;
        else return s[31:0];
    endfunction

    logic signed [31:0] s_end, w_end;
    logic [IW-1:0] s_ci, w_ci;
    assign s_ci = (found_reg && seg == '0) ? '0 : IW'(sc - SW'(1));
    assign w_ci = (found_reg && seg == '0) ? '0 : IW'(wc - SW'(1));
    assign s_end = s_mem[s_ci];
    assign w_end = w_mem[w_ci];

    // result registers
    always_ff @(posedge clk)
    begin
        if (cmd.sum)
        begin
            strength_out <= cs_flag ? s_end
                : sat_shift((PW+1)'(ps1_reg) + (PW+1)'(ps0_reg));
            width_out <= cw_flag ? w_end
                : sat_shift((PW+1)'(pw1_reg) + (PW+1)'(pw0_reg));
            segment <= CNT_W'(seg);
            clamped <= cs_flag;
        end
    end

    a_seg_range: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (32'(seg) <= MAX_POINTS)) else $error("segment out of range");
    a_div_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> cnt_reg == QCW'(NW)) else $error("divider not loaded");
    a_search_stop: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && !cmd.start) |=> done_reg) else $error("search restarted");
endmodule
`default_nettype wire

[rtl/breakpoint_table_linear_interpolator_top.sv]
// Top level: stream ports, configuration registers, controller and datapath.
// Depends on btli_pkg, btli_ctrl, btli_datapath.
//
// Breakpoint table interpolator with a 16-entry table. A load item (tuser=0)
// writes one entry in its accept cycle and gives no result; a query item
// (tuser=1) gives one result. One item at a time: after the accept cycle a
// query runs the serial search (a match at index i ends it, and with no match
// it ends after the time_count entries), then, only when a result is
// interpolated, the bit-serial divider and the multiply step, then the
// sum-and-saturate step and the output state, which holds until the result
// is taken. Table contents are undefined until written.
`default_nettype none
module breakpoint_table_linear_interpolator_top #(
    parameter int FRACTION_BITS = btli_pkg::FRACTION_BITS_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [135:0] s_tdata,  // entry_index, entry_time, entry_strength,
                                        // entry_width, query_time, pad
    input  wire logic         s_tuser,  // mode
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [71:0]       m_tdata,  // strength_out, width_out, segment, pad
    output logic              m_tuser,  // clamped
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [4:0]   cfg_data
);
    import btli_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic [CNT_W-1:0] tc_reg, sc_reg, wc_reg;
    logic signed [31:0] s_o, w_o;
    logic [CNT_W-1:0] seg_o;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tc_reg <= CNT_W'(1);
            sc_reg <= CNT_W'(1);
            wc_reg <= CNT_W'(1);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_TIME_COUNT:     tc_reg <= cfg_data;
                REG_STRENGTH_COUNT: sc_reg <= cfg_data;
                REG_WIDTH_COUNT:    wc_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    btli_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (s_tvalid && s_tready),
        .in_mode  (s_tuser),
        .out_fire (m_tvalid && m_tready),
        .stat     (stat),
        .cmd      (cmd),
        .s_ready  (s_tready),
        .m_valid  (m_tvalid)
    );

    btli_datapath #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .entry_index    (s_tdata[3:0]),
        .entry_time     (s_tdata[35:4]),
        .entry_strength (s_tdata[67:36]),
        .entry_width    (s_tdata[99:68]),
        .query_time     (s_tdata[131:100]),
        .time_count     (tc_reg),
        .strength_count (sc_reg),
        .width_count    (wc_reg),
        .strength_out   (s_o),
        .width_out      (w_o),
        .segment        (seg_o),
        .clamped        (m_tuser)
    );

    assign m_tdata = {3'b000, seg_o, w_o, s_o};
endmodule
`default_nettype wire
